>>> sv/pbaq_pkg.sv
// ----------------------------------------------------------------------------
// pbaq_pkg
// Shared constants, types and helper functions of the palette block average
// quantizer.
// ----------------------------------------------------------------------------
package pbaq_pkg;

  localparam int MAX_BLOCK_PIXELS = 65536;
  localparam int SEARCH_ENTRIES   = 240;
  localparam int TABLE_DEPTH      = 240;

  localparam int COLOR_W      = 8;
  localparam int NUM_LANES    = 3;
  localparam int ENTRY_W      = NUM_LANES * COLOR_W;
  localparam int INDEX_W      = 8;
  localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
  localparam int COUNT_W      = $clog2(MAX_BLOCK_PIXELS + 1);
  localparam int SUM_W        = $clog2(255 * MAX_BLOCK_PIXELS + 1);
  localparam int QUOT_W       = COLOR_W;
  localparam int DIV_W        = COUNT_W + QUOT_W;
  localparam int DIV_CNT_W    = $clog2(QUOT_W);
  localparam int SQ_W         = 2 * COLOR_W;
  localparam int DIST_W       = $clog2(3 * 255 * 255 + 1);
  localparam int SRCH_CNT_W   = $clog2(SEARCH_ENTRIES + 1);

  localparam logic [INDEX_W-1:0] TRANSPARENT_INDEX = 8'd255;
  localparam logic [INDEX_W-1:0] FULLBRIGHT_FIRST  = 8'd240;

  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FIN,
    ST_DIV,
    ST_BASE,
    ST_SRCH,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pal_wr;
    logic pix_cap;
    logic pix_acc;
    logic div_start;
    logic div_step;
    logic base_load;
    logic srch_step;
    logic res_load;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pix_last;
    logic special;
    logic div_last;
    logic srch_done;
  } sts_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

>>> sv/pbaq_ram.sv
// ----------------------------------------------------------------------------
// pbaq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pbaq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/pbaq_dp.sv
// ----------------------------------------------------------------------------
// pbaq_dp
// Datapath: palette memory, block accumulators, three-lane serial divider,
// two-stage distance pipeline for the palette search, and result registers.
// ----------------------------------------------------------------------------
module pbaq_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pbaq_pkg::cmd_t                 cmd,
  input  logic [pbaq_pkg::INDEX_W-1:0]   in_pixel_index,
  input  logic [pbaq_pkg::COLOR_W-1:0]   in_red,
  input  logic [pbaq_pkg::COLOR_W-1:0]   in_green,
  input  logic [pbaq_pkg::COLOR_W-1:0]   in_blue,
  input  logic                           in_last,
  output pbaq_pkg::sts_t                 sts,
  output logic [pbaq_pkg::INDEX_W-1:0]   out_color_index
);
  import pbaq_pkg::*;

  // Palette memory ports.
  logic                    ram_wr_en;
  logic [TABLE_ADDR_W-1:0] ram_wr_addr;
  logic                    ram_rd_en;
  logic [TABLE_ADDR_W-1:0] ram_rd_addr;
  logic [ENTRY_W-1:0]      ram_rd_data;
  logic                    srch_issue;

  // Captured pixel.
  logic [INDEX_W-1:0] pix_idx_r;
  logic               pix_last_r;

  // Block accumulators.
  logic [SUM_W-1:0]   sum_r   [NUM_LANES];
  logic [SUM_W-1:0]   sum_nxt [NUM_LANES];
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               fb_seen_r, fb_seen_nxt;
  logic [INDEX_W-1:0] fb_idx_r, fb_idx_nxt;
  logic               visible;

  // Divider lanes.
  logic [DIV_W-1:0]     rem_r   [NUM_LANES];
  logic [DIV_W-1:0]     rem_nxt [NUM_LANES];
  logic [QUOT_W-1:0]    quot_r  [NUM_LANES];
  logic [QUOT_W-1:0]    quot_nxt[NUM_LANES];
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Search pipeline.
  logic [SRCH_CNT_W-1:0] srch_addr_r;
  logic                  s0_v_r, s0_tab_r;
  logic [INDEX_W-1:0]    s0_idx_r;
  logic                  s1_v_r;
  logic [INDEX_W-1:0]    s1_idx_r;
  logic [DIST_W-1:0]     dist_r;
  logic [ENTRY_W-1:0]    entry;
  logic [DIST_W-1:0]     best_r;
  logic [INDEX_W-1:0]    best_idx_r;

  logic [INDEX_W-1:0] result_r;
  logic [INDEX_W-1:0] out_color_index_r;

  assign srch_issue  = cmd.srch_step && (srch_addr_r < SRCH_CNT_W'(SEARCH_ENTRIES));
  assign ram_wr_en   = cmd.pal_wr && (in_pixel_index < TABLE_DEPTH);
  assign ram_wr_addr = TABLE_ADDR_W'(in_pixel_index);
  assign ram_rd_en   = (cmd.pix_cap && (in_pixel_index < TABLE_DEPTH)) ||
                       (srch_issue && (srch_addr_r < TABLE_DEPTH));
  assign ram_rd_addr = cmd.pix_cap ? TABLE_ADDR_W'(in_pixel_index)
                                   : TABLE_ADDR_W'(srch_addr_r);

  pbaq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.pix_cap) begin
      pix_idx_r  <= in_pixel_index;
      pix_last_r <= in_last;
    end
  end

  // A pixel counts toward the average only if it is opaque, not fullbright,
  // and the block has not yet hit its pixel limit.
  assign visible = !fb_seen_r && (pix_idx_r != TRANSPARENT_INDEX) &&
                   (pix_idx_r < FULLBRIGHT_FIRST) &&
                   (count_r < COUNT_W'(MAX_BLOCK_PIXELS));

  always_comb begin
    count_nxt   = count_r;
    fb_seen_nxt = fb_seen_r;
    fb_idx_nxt  = fb_idx_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      sum_nxt[l] = sum_r[l];
    end
    if (cmd.res_load) begin
      count_nxt   = '0;
      fb_seen_nxt = 1'b0;
      fb_idx_nxt  = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        sum_nxt[l] = '0;
      end
    end else if (cmd.pix_acc) begin
      if (!fb_seen_r && (pix_idx_r != TRANSPARENT_INDEX) &&
          (pix_idx_r >= FULLBRIGHT_FIRST)) begin
        fb_seen_nxt = 1'b1;
        fb_idx_nxt  = pix_idx_r;
      end else if (visible) begin
        count_nxt = count_r + COUNT_W'(1);
        for (int l = 0; l < NUM_LANES; l++) begin
          sum_nxt[l] = sum_r[l] +
                       SUM_W'(ram_rd_data[COLOR_W*(NUM_LANES-1-l) +: COLOR_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      fb_seen_r <= 1'b0;
      fb_idx_r  <= '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        sum_r[l] <= '0;
      end
    end else begin
      count_r   <= count_nxt;
      fb_seen_r <= fb_seen_nxt;
      fb_idx_r  <= fb_idx_nxt;
      for (int l = 0; l < NUM_LANES; l++) begin
        sum_r[l] <= sum_nxt[l];
      end
    end
  end

  // Restoring division, one quotient bit per cycle. The mean of 8-bit values
  // never exceeds 255, so eight steps starting at count << 7 are enough.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (cmd.div_start) begin
        rem_nxt[l]  = DIV_W'(sum_r[l]);
        quot_nxt[l] = '0;
      end else if (cmd.div_step && (rem_r[l] >= dvs_r)) begin
        rem_nxt[l]  = rem_r[l] - dvs_r;
        quot_nxt[l] = {quot_r[l][QUOT_W-2:0], 1'b1};
      end else if (cmd.div_step) begin
        rem_nxt[l]  = rem_r[l];
        quot_nxt[l] = {quot_r[l][QUOT_W-2:0], 1'b0};
      end else begin
        rem_nxt[l]  = rem_r[l];
        quot_nxt[l] = quot_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_r[l]  <= rem_nxt[l];
      quot_r[l] <= quot_nxt[l];
    end
    if (cmd.div_start) begin
      dvs_r     <= DIV_W'({count_r, {(QUOT_W-1){1'b0}}});
      div_cnt_r <= DIV_CNT_W'(QUOT_W - 1);
    end else if (cmd.div_step) begin
      dvs_r     <= dvs_r >> 1;
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
  end

  // Entries past the end of the palette read as black.
  assign entry = s0_tab_r ? ram_rd_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_addr_r <= '0;
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
    end else if (cmd.base_load) begin
      srch_addr_r <= '0;
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      if (srch_issue) begin
        srch_addr_r <= srch_addr_r + SRCH_CNT_W'(1);
      end
      s0_v_r <= srch_issue;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx_r <= INDEX_W'(srch_addr_r);
    s0_tab_r <= srch_addr_r < TABLE_DEPTH;
    s1_idx_r <= s0_idx_r;
    dist_r   <= DIST_W'(sq_diff(quot_r[0], entry[COLOR_W*2 +: COLOR_W])) +
                DIST_W'(sq_diff(quot_r[1], entry[COLOR_W +: COLOR_W])) +
                DIST_W'(sq_diff(quot_r[2], entry[0 +: COLOR_W]));
    if (cmd.base_load) begin
      // The search opens with the distance to black and index 0.
      best_r     <= DIST_W'(sq_diff(quot_r[0], '0)) +
                    DIST_W'(sq_diff(quot_r[1], '0)) +
                    DIST_W'(sq_diff(quot_r[2], '0));
      best_idx_r <= '0;
    end else if (s1_v_r && (dist_r < best_r)) begin
      best_r     <= dist_r;
      best_idx_r <= s1_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (fb_seen_r) begin
        result_r <= fb_idx_r;
      end else if (count_r == '0) begin
        result_r <= TRANSPARENT_INDEX;
      end else begin
        result_r <= best_idx_r;
      end
    end
    if (cmd.load_out) begin
      out_color_index_r <= result_r;
    end
  end

  assign out_color_index = out_color_index_r;

  assign sts.pix_last  = pix_last_r;
  assign sts.special   = fb_seen_r || (count_r == '0);
  assign sts.div_last  = (div_cnt_r == '0);
  assign sts.srch_done = (srch_addr_r == SRCH_CNT_W'(SEARCH_ENTRIES)) &&
                         !s0_v_r && !s1_v_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_BLOCK_PIXELS))
    else $error("visible pixel count exceeds the block limit");

  a_fb_range: assert property (@(posedge clk) disable iff (!rst_n)
    fb_seen_r |-> (fb_idx_r >= FULLBRIGHT_FIRST) && (fb_idx_r != TRANSPARENT_INDEX))
    else $error("fullbright index outside the fullbright range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start || cmd.div_step) |-> (count_r != '0))
    else $error("division started with a zero pixel count");

endmodule

>>> sv/pbaq_ctrl.sv
// ----------------------------------------------------------------------------
// pbaq_ctrl
// Controller: sequences pixel accumulation, division and palette search, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module pbaq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  pbaq_pkg::sts_t sts,
  output pbaq_pkg::cmd_t cmd
);
  import pbaq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_operation == OP_PIXEL)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC:  state_nxt = sts.pix_last ? ST_FIN : ST_IDLE;
      ST_FIN:  state_nxt = sts.special ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: state_nxt = ST_SRCH;
      ST_SRCH: begin
        if (sts.srch_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.pal_wr  = in_valid && (in_operation == OP_PAL_WRITE);
        cmd.pix_cap = in_valid && (in_operation == OP_PIXEL);
      end
      ST_ACC: cmd.pix_acc = 1'b1;
      ST_FIN: begin
        cmd.res_load  = sts.special;
        cmd.div_start = !sts.special;
      end
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_BASE: cmd.base_load = 1'b1;
      ST_SRCH: begin
        cmd.srch_step = !sts.srch_done;
        cmd.res_load  = sts.srch_done;
      end
      ST_OUT:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // The output register holds a finished beat while the next block fills.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_pixel_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_PIXEL)) |=> (state_r == ST_ACC))
    else $error("accepted pixel did not move to accumulation");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result beat appeared outside the output state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("pending result beat overwritten");

endmodule

>>> sv/palette_block_average_quantizer.sv
// ----------------------------------------------------------------------------
// palette_block_average_quantizer
// Averages a block of palette-indexed pixels and maps the mean color back to
// the nearest palette entry.
// ----------------------------------------------------------------------------
// Palette write: taken while idle. Pixel: palette read, then accumulate. A
// last pixel goes straight to output for a fullbright or fully transparent
// block, else through 8 serial divide steps, 240 palette reads, the distance
// pipeline drain, and setup and output; an earlier result still held by a
// stall delays the output step. Synchronous active-low reset clears the
// accumulators and the handshake; the palette memory must be written first.
module palette_block_average_quantizer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [pbaq_pkg::INDEX_W-1:0] in_pixel_index,
  input  logic [pbaq_pkg::COLOR_W-1:0] in_red,
  input  logic [pbaq_pkg::COLOR_W-1:0] in_green,
  input  logic [pbaq_pkg::COLOR_W-1:0] in_blue,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pbaq_pkg::INDEX_W-1:0] out_color_index
);
  import pbaq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pbaq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  pbaq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_pixel_index  (in_pixel_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_last         (in_last),
    .sts             (sts),
    .out_color_index (out_color_index)
  );

endmodule

>>> verif/pbaq_checker.sv
// ----------------------------------------------------------------------------
// pbaq_checker
// Watches both channels of the palette block average quantizer, keeps its own
// copy of the palette and block accumulators, predicts the color index of
// every finished block and compares it with each result beat in order.
// ----------------------------------------------------------------------------
module pbaq_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_operation,
  input  logic [pbaq_pkg::INDEX_W-1:0] in_pixel_index,
  input  logic [pbaq_pkg::COLOR_W-1:0] in_red,
  input  logic [pbaq_pkg::COLOR_W-1:0] in_green,
  input  logic [pbaq_pkg::COLOR_W-1:0] in_blue,
  input  logic                         in_last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [pbaq_pkg::INDEX_W-1:0] out_color_index,
  output int                           fail_count,
  output int                           pending_count
);
  import pbaq_pkg::*;

  logic [COLOR_W-1:0] shadow_red   [TABLE_DEPTH];
  logic [COLOR_W-1:0] shadow_green [TABLE_DEPTH];
  logic [COLOR_W-1:0] shadow_blue  [TABLE_DEPTH];

  logic [SUM_W-1:0]   acc_red;
  logic [SUM_W-1:0]   acc_green;
  logic [SUM_W-1:0]   acc_blue;
  logic [COUNT_W-1:0] visible_pixels;
  logic               bright_hit;
  logic [INDEX_W-1:0] bright_index;

  logic [INDEX_W-1:0] block_index_q[$];
  logic [INDEX_W-1:0] wanted_index;

  // Squared distance from the mean color to each entry; ties keep the
  // earlier entry, and black with index 0 is the starting point.
  function automatic logic [INDEX_W-1:0] nearest_entry(input int mean_r,
                                                       input int mean_g,
                                                       input int mean_b);
    int best;
    int span;
    int dr;
    int dg;
    int db;
    logic [INDEX_W-1:0] pick;
    pick = '0;
    best = mean_r * mean_r + mean_g * mean_g + mean_b * mean_b;
    for (int i = 0; i < SEARCH_ENTRIES && i < 256; i++) begin
      dr = mean_r;
      dg = mean_g;
      db = mean_b;
      if (i < TABLE_DEPTH) begin
        dr = mean_r - int'(shadow_red[i]);
        dg = mean_g - int'(shadow_green[i]);
        db = mean_b - int'(shadow_blue[i]);
      end
      span = dr * dr + dg * dg + db * db;
      if (span < best) begin
        best = span;
        pick = INDEX_W'(i);
      end
    end
    return pick;
  endfunction

  function automatic logic [INDEX_W-1:0] block_color_index();
    if (bright_hit)
      return bright_index;
    if (visible_pixels == 0)
      return TRANSPARENT_INDEX;
    return nearest_entry(int'(acc_red / visible_pixels),
                         int'(acc_green / visible_pixels),
                         int'(acc_blue / visible_pixels));
  endfunction

  task automatic clear_block();
    acc_red        = '0;
    acc_green      = '0;
    acc_blue       = '0;
    visible_pixels = '0;
    bright_hit     = 1'b0;
    bright_index   = '0;
  endtask

  task automatic apply_input_beat();
    if (in_operation == OP_PAL_WRITE) begin
      if (in_pixel_index < TABLE_DEPTH) begin
        shadow_red[in_pixel_index]   = in_red;
        shadow_green[in_pixel_index] = in_green;
        shadow_blue[in_pixel_index]  = in_blue;
      end
    end else begin
      if (!bright_hit && in_pixel_index != TRANSPARENT_INDEX) begin
        if (in_pixel_index >= FULLBRIGHT_FIRST) begin
          bright_hit   = 1'b1;
          bright_index = in_pixel_index;
        end else if (visible_pixels < MAX_BLOCK_PIXELS) begin
          acc_red        = acc_red + shadow_red[in_pixel_index];
          acc_green      = acc_green + shadow_green[in_pixel_index];
          acc_blue       = acc_blue + shadow_blue[in_pixel_index];
          visible_pixels = visible_pixels + 1'b1;
        end
      end
      if (in_last) begin
        block_index_q = {block_index_q, block_color_index()};
        clear_block();
      end
    end
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_block();
      block_index_q.delete();
      pending_count <= 0;
    end else begin
      // A result beat can never belong to the input beat of the same edge.
      if (out_valid && !out_stall) begin
        if (block_index_q.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: color index %0d",
                                 out_color_index));
        end else begin
          wanted_index = block_index_q.pop_front();
          if (out_color_index !== wanted_index)
            note_failure($sformatf("color index mismatch: expected %0d, got %0d",
                                   wanted_index, out_color_index));
        end
      end
      if (in_valid && !in_stall)
        apply_input_beat();
      pending_count <= block_index_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the palette block average quantizer. Loads the whole palette,
// runs directed blocks for the transparent, fullbright, tie and ignored-write
// cases, then random blocks mixed with palette rewrites, under random sender
// gaps and receiver stalls. The checker module predicts and compares every
// result beat.
// ----------------------------------------------------------------------------
module tb;
  import pbaq_pkg::*;

  localparam int RANDOM_ITEMS  = 340;
  localparam int DRAIN_CYCLES  = 300;
  localparam int STALL_NONE    = 0;
  localparam int STALL_HOLD    = 1;
  localparam int STALL_CHOPPY  = 2;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_operation   = OP_PIXEL;
  logic [INDEX_W-1:0] in_pixel_index = '0;
  logic [COLOR_W-1:0] in_red         = '0;
  logic [COLOR_W-1:0] in_green       = '0;
  logic [COLOR_W-1:0] in_blue        = '0;
  logic               in_last        = 1'b0;
  logic               out_stall      = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [INDEX_W-1:0] out_color_index;

  int fail_count;
  int pending_count;
  int burst_left   = 0;
  int random_items = 0;
  int stall_hold   = 0;
  int stall_mode   = STALL_NONE;

  palette_block_average_quantizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_pixel_index  (in_pixel_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_index (out_color_index)
  );

  pbaq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_pixel_index  (in_pixel_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_index (out_color_index),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  always #5 clk = ~clk;

  // The receiver switches between quiet, held and choppy stretches.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_hold <= $urandom_range(1, 40);
      stall_mode <= $urandom_range(STALL_NONE, STALL_CHOPPY);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_HOLD: out_stall <= 1'b1;
      default:    out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  // Presents one beat and returns at the edge where it is accepted.
  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                           input logic [COLOR_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_pixel_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_last        <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left != 0)
      burst_left--;
  endtask

  // Color fields ride along on pixel beats with random content.
  task automatic send_pixel(input logic [INDEX_W-1:0] idx, input logic last);
    send_beat(OP_PIXEL, idx, COLOR_W'($urandom), COLOR_W'($urandom),
              COLOR_W'($urandom), last);
  endtask

  task automatic send_random_write();
    send_beat(OP_PAL_WRITE, INDEX_W'($urandom_range(0, 255)), COLOR_W'($urandom),
              COLOR_W'($urandom), COLOR_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [INDEX_W-1:0] pick_pixel_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80)
      return INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
    if (roll < 90)
      return TRANSPARENT_INDEX;
    if (roll < 95)
      return INDEX_W'($urandom_range(FULLBRIGHT_FIRST, 254));
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  // Mostly 2x2 blocks, others of 1 to 16 pixels, a few fully transparent, and
  // now and then a palette write dropped into a block.
  task automatic send_random_block();
    int  len;
    bit  all_clear;
    len       = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 16);
    all_clear = ($urandom_range(0, 19) == 0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_random_write();
        random_items++;
      end
      send_pixel(all_clear ? TRANSPARENT_INDEX : pick_pixel_index(), k == len - 1);
      random_items++;
    end
  endtask

  initial begin
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every entry is written before any pixel or search can read it.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r = COLOR_W'($urandom);
      g = COLOR_W'($urandom);
      b = COLOR_W'($urandom);
      case (i)
        1: begin
          r = 8'd255; g = 8'd255; b = 8'd255;
        end
        2: begin
          r = 8'd0; g = 8'd0; b = 8'd0;
        end
        3: begin
          r = 8'd247; g = 8'd247; b = 8'd247;
        end
        5, 6: begin
          r = 8'd128; g = 8'd64; b = 8'd32;
        end
        default: ;
      endcase
      send_beat(OP_PAL_WRITE, INDEX_W'(i), r, g, b, 1'b0);
    end

    send_pixel(8'd1, 1'b1);
    send_pixel(TRANSPARENT_INDEX, 1'b0);
    send_pixel(TRANSPARENT_INDEX, 1'b1);
    send_pixel(FULLBRIGHT_FIRST, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd254, 1'b1);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd254, 1'b1);
    send_pixel(TRANSPARENT_INDEX, 1'b0);
    send_pixel(8'd247, 1'b0);
    send_pixel(8'd9, 1'b1);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd2, 1'b1);
    send_pixel(8'd5, 1'b1);
    send_beat(OP_PAL_WRITE, FULLBRIGHT_FIRST, 8'd0, 8'd0, 8'd0, 1'b1);
    send_beat(OP_PAL_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_beat(OP_PAL_WRITE, 8'd4, 8'd10, 8'd200, 8'd90, 1'b1);
    send_pixel(8'd239, 1'b1);
    send_pixel(8'd0, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random_write();
        random_items++;
      end else begin
        send_random_block();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
sv/pbaq_pkg.sv
sv/pbaq_ram.sv
sv/pbaq_dp.sv
sv/pbaq_ctrl.sv
sv/palette_block_average_quantizer.sv
verif/pbaq_checker.sv
verif/tb.sv
